// ----- rtl/wfd_pkg.sv -----
// Shared types, constants and helpers of the WebSocket frame decoder.
// Used by wfd_parser, wfd_out_reg and websocket_frame_decoder_unit.
`default_nettype none

package wfd_pkg;

  localparam int LengthBits = 64;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

  localparam logic [3:0] OpContinue = 4'h0;
  localparam logic [3:0] OpBinary   = 4'h2;
  localparam logic [3:0] OpClose    = 4'h8;
  localparam logic [3:0] OpPing     = 4'h9;
  localparam logic [3:0] OpPong     = 4'hA;

  localparam logic [2:0] KindData  = 3'd0;
  localparam logic [2:0] KindPing  = 3'd1;
  localparam logic [2:0] KindPong  = 3'd2;
  localparam logic [2:0] KindClose = 3'd3;
  localparam logic [2:0] KindOther = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [2:0] frame_kind;
    logic [3:0] frame_opcode;
    logic       final_flag;
    logic       last_of_frame;
    logic       msg_done;
  } result_t;

  function automatic logic [2:0] kind_of(input logic [3:0] op);
    logic [2:0] k;
    if (op <= OpBinary) k = KindData;
    else if (op == OpPing) k = KindPing;
    else if (op == OpPong) k = KindPong;
    else if (op == OpClose) k = KindClose;
    else k = KindOther;
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wfd_parser.sv -----
// Frame header parser and payload unmasking for one registered byte a cycle while advance is high.
// Depends on wfd_pkg for the phase type, length codes and result layout.
`default_nettype none

module wfd_parser #(
  parameter int LENGTH_BITS = wfd_pkg::LengthBits
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [7:0]      rx_byte,
  output wfd_pkg::result_t     res,
  output logic                 emit
);
  import wfd_pkg::*;

  phase_t                 phase, phase_next;
  logic [3:0]             extra_left, extra_left_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;
  logic [1:0]             key_index, key_index_next;
  logic [31:0]            key_word, key_word_next;
  logic                   is_masked, is_masked_next;
  logic [3:0]             current_opcode, current_opcode_next;
  logic                   current_fin, current_fin_next;

  logic [6:0]             code;
  logic [LENGTH_BITS-1:0] code_len;
  logic [LENGTH_BITS-1:0] ext_len;
  logic [LENGTH_BITS-1:0] dec_len;
  logic                   ext_done;
  logic                   ext_zero;
  logic                   left_zero;
  logic                   left_one;
  logic [7:0]             key_byte;
  logic                   empty_frame;
  logic                   last;
  logic [2:0]             kind;

  assign code      = rx_byte[6:0];
  assign code_len  = LENGTH_BITS'(code);
  assign ext_len   = {payload_left[LENGTH_BITS-9:0], rx_byte};
  assign dec_len   = payload_left - LENGTH_BITS'(1);
  assign ext_done  = (extra_left == 4'd1);
  assign ext_zero  = (ext_len == '0);
  assign left_zero = (payload_left == '0);
  assign left_one  = (payload_left == LENGTH_BITS'(1));
  assign key_byte  = key_word[8*(3-key_index) +: 8];
  assign kind      = kind_of(current_opcode);

  always_comb begin
    phase_next          = phase;
    extra_left_next     = extra_left;
    payload_left_next   = payload_left;
    key_index_next      = key_index;
    key_word_next       = key_word;
    is_masked_next      = is_masked;
    current_opcode_next = current_opcode;
    current_fin_next    = current_fin;
    case (phase)
      PH_HDR1: begin
        is_masked_next = rx_byte[7];
        if (code == LenCode16 || code == LenCode64) begin
          payload_left_next = '0;
          extra_left_next   = (code == LenCode16) ? ExtBytes16 : ExtBytes64;
          phase_next        = PH_EXT;
        end else begin
          payload_left_next = code_len;
          key_index_next    = 2'd0;
          if (rx_byte[7]) begin
            phase_next = PH_KEY;
          end else begin
            key_word_next = '0;
            phase_next    = (code == 7'd0) ? PH_HDR0 : PH_DATA;
          end
        end
      end
      PH_EXT: begin
        payload_left_next = ext_len;
        extra_left_next   = extra_left - 4'd1;
        if (ext_done) begin
          key_index_next = 2'd0;
          if (is_masked) begin
            phase_next = PH_KEY;
          end else begin
            key_word_next = '0;
            phase_next    = ext_zero ? PH_HDR0 : PH_DATA;
          end
        end
      end
      PH_KEY: begin
        key_word_next  = {key_word[23:0], rx_byte};
        key_index_next = key_index + 2'd1;
        if (key_index == 2'd3) begin
          phase_next = left_zero ? PH_HDR0 : PH_DATA;
        end
      end
      PH_DATA: begin
        key_index_next    = key_index + 2'd1;
        payload_left_next = dec_len;
        if (left_one) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        current_fin_next    = rx_byte[7];
        current_opcode_next = rx_byte[3:0];
        phase_next          = PH_HDR1;
      end
    endcase
  end

  always_comb begin
    empty_frame = 1'b0;
    case (phase)
      PH_HDR1: empty_frame = !rx_byte[7] && (code == 7'd0);
      PH_EXT:  empty_frame = ext_done && !is_masked && ext_zero;
      PH_KEY:  empty_frame = (key_index == 2'd3) && left_zero;
      default: empty_frame = 1'b0;
    endcase
    emit = (phase == PH_DATA) || empty_frame;
    last = (phase == PH_DATA) ? left_one : 1'b1;
    res.payload_byte  = (phase == PH_DATA) ? (rx_byte ^ key_byte) : 8'd0;
    res.has_byte      = (phase == PH_DATA);
    res.frame_kind    = kind;
    res.frame_opcode  = current_opcode;
    res.final_flag    = current_fin;
    res.last_of_frame = last;
    res.msg_done      = last && (kind == KindData) && current_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      extra_left     <= '0;
      payload_left   <= '0;
      key_index      <= '0;
      key_word       <= '0;
      is_masked      <= 1'b0;
      current_opcode <= '0;
      current_fin    <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      extra_left     <= extra_left_next;
      payload_left   <= payload_left_next;
      key_index      <= key_index_next;
      key_word       <= key_word_next;
      is_masked      <= is_masked_next;
      current_opcode <= current_opcode_next;
      current_fin    <= current_fin_next;
    end
  end

  a_data_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> payload_left != '0)
    else $error("payload phase with no bytes left");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    emit && res.msg_done |-> res.last_of_frame && res.frame_kind == KindData)
    else $error("message end off a data frame end");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    emit && !res.has_byte |-> res.payload_byte == 8'd0 && res.last_of_frame)
    else $error("empty frame marker malformed");

  a_leave_data: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_DATA && left_one |=> phase == PH_HDR0)
    else $error("payload end not followed by header");

endmodule

`default_nettype wire

// ----- rtl/wfd_out_reg.sv -----
// Result register of the frame decoder: holds one result beat until taken.
// Depends on wfd_pkg for the result layout.
`default_nettype none

module wfd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire wfd_pkg::result_t res,
  input  wire logic             out_stall,
  output logic                  out_free,
  output logic                  out_valid,
  output logic [7:0]            payload_byte,
  output logic                  has_byte,
  output logic [2:0]            frame_kind,
  output logic [3:0]            frame_opcode,
  output logic                  final_flag,
  output logic                  last_of_frame,
  output logic                  msg_done
);
  import wfd_pkg::*;

  result_t held;
  logic    valid;

  assign out_free = !valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!out_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out_valid     = valid;
  assign payload_byte  = held.payload_byte;
  assign has_byte      = held.has_byte;
  assign frame_kind    = held.frame_kind;
  assign frame_opcode  = held.frame_opcode;
  assign final_flag    = held.final_flag;
  assign last_of_frame = held.last_of_frame;
  assign msg_done      = held.msg_done;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result register overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(held))
    else $error("stalled result dropped or changed");

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_decoder_unit.sv -----
// WebSocket receive-side frame decoder, top level.
// Input byte register, wfd_parser and wfd_out_reg; depends on wfd_pkg.
//
// Use:
//   Input channel: in_valid, in_stall, rx_byte. One received byte per beat,
//   in stream order, header bytes and payload bytes alike.
//   Output channel: out_valid, out_stall and the result fields. One beat per
//   payload byte (unmasked, tagged with kind, opcode and FIN), and one beat
//   with has_byte low for a frame with an empty payload. Header bytes that
//   end no frame give no beat.
//   Path: an accepted byte is held in the input register, decoded by the parser
//   and its result held in the result register, which presents it.
//   Throughput: one byte per cycle while no stalled result blocks it, bound by
//   the single pass from the input register through the parser to the result register.
//   Stalls: when out_stall holds a result, a byte that gives no result still
//   advances; a byte that gives a result waits in the input register and
//   in_stall rises until the result register frees.
//   Reset: rst empties both registers and clears the parser; the next byte is taken
//   as the first header byte of a frame.
`default_nettype none

module websocket_frame_decoder_unit #(
  parameter int LENGTH_BITS = wfd_pkg::LengthBits
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      payload_byte,
  output logic            has_byte,
  output logic [2:0]      frame_kind,
  output logic [3:0]      frame_opcode,
  output logic            final_flag,
  output logic            last_of_frame,
  output logic            msg_done
);
  import wfd_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       accept;
  logic       emit;
  logic       out_free;
  result_t    res;

  assign advance  = in_full && (!emit || out_free);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= rx_byte;
    end
  end

  wfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .rx_byte(in_byte),
    .res    (res),
    .emit   (emit)
  );

  wfd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && emit),
    .res          (res),
    .out_stall    (out_stall),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .payload_byte (payload_byte),
    .has_byte     (has_byte),
    .frame_kind   (frame_kind),
    .frame_opcode (frame_opcode),
    .final_flag   (final_flag),
    .last_of_frame(last_of_frame),
    .msg_done     (msg_done)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && emit && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_byte))
    else $error("waiting byte lost");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_full)
    else $error("accepted byte not registered");

endmodule

`default_nettype wire

// ----- test/websocket_frame_decoder_unit_tb.sv -----
// Testbench for websocket_frame_decoder_unit: a directed frame table, then random frames.
// Each output beat is checked against the table's result or a built-in frame parser;
// sender bursts and receiver stalls. Depends on wfd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module websocket_frame_decoder_unit_tb;
  import wfd_pkg::*;

  localparam logic [3:0] OpText = 4'h1;
  localparam logic [3:0] OpUnknown = 4'h3;
  localparam result_t NoResult = '0;
  localparam int StimBytes = 1725;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic [2:0] frame_kind;
  logic [3:0] frame_opcode;
  logic       final_flag;
  logic       last_of_frame;
  logic       msg_done;

  // frame parser state
  phase_t      hdr_state = PH_HDR0;
  logic [3:0]  len_bytes_due = '0;
  logic [63:0] bytes_due = '0;
  logic [1:0]  key_pos = '0;
  logic [31:0] unmask_key = '0;
  logic        key_on = 1'b0;
  logic [3:0]  frame_op = '0;
  logic        frame_fin = 1'b0;
  bit          res_ready;
  result_t     res_next;

  result_t   decoded_q[$];
  stim_row_t dir_rows[0:24];
  int        bytes_sent = 0;
  int        burst_left = 0;
  int        stall_left = 0;
  int        stall_mode = 0;
  bit        failed = 1'b0;

  websocket_frame_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .payload_byte(payload_byte),
    .has_byte(has_byte),
    .frame_kind(frame_kind),
    .frame_opcode(frame_opcode),
    .final_flag(final_flag),
    .last_of_frame(last_of_frame),
    .msg_done(msg_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t tag_result(logic [7:0] pb, logic has, logic last);
    result_t r;
    r.payload_byte = pb;
    r.has_byte = has;
    case (frame_op)
      OpContinue, OpText, OpBinary: r.frame_kind = KindData;
      OpPing: r.frame_kind = KindPing;
      OpPong: r.frame_kind = KindPong;
      OpClose: r.frame_kind = KindClose;
      default: r.frame_kind = KindOther;
    endcase
    r.frame_opcode = frame_op;
    r.final_flag = frame_fin;
    r.last_of_frame = last;
    r.msg_done = last && frame_fin && (r.frame_kind == KindData);
    return r;
  endfunction

  task automatic open_payload();
    key_pos = '0;
    if (bytes_due == '0) begin
      hdr_state = PH_HDR0;
      res_ready = 1'b1;
      res_next = tag_result(8'h00, 1'b0, 1'b1);
    end else begin
      hdr_state = PH_DATA;
    end
  endtask

  task automatic length_done();
    if (key_on) begin
      key_pos = '0;
      hdr_state = PH_KEY;
    end else begin
      unmask_key = '0;
      open_payload();
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int shift;
    res_ready = 1'b0;
    res_next = NoResult;
    case (hdr_state)
      PH_HDR1: begin
        key_on = b[7];
        if (b[6:0] == LenCode16 || b[6:0] == LenCode64) begin
          bytes_due = '0;
          len_bytes_due = (b[6:0] == LenCode16) ? ExtBytes16 : ExtBytes64;
          hdr_state = PH_EXT;
        end else begin
          bytes_due = 64'(b[6:0]);
          length_done();
        end
      end
      PH_EXT: begin
        bytes_due = {bytes_due[55:0], b};
        len_bytes_due = len_bytes_due - 4'd1;
        if (len_bytes_due == '0) length_done();
      end
      PH_KEY: begin
        unmask_key = {unmask_key[23:0], b};
        key_pos = key_pos + 2'd1;
        if (key_pos == '0) open_payload();
      end
      PH_DATA: begin
        shift = 24 - 8 * int'(key_pos);
        key_pos = key_pos + 2'd1;
        bytes_due = bytes_due - 64'd1;
        res_ready = 1'b1;
        res_next = tag_result(b ^ unmask_key[shift +: 8], 1'b1, bytes_due == '0);
        if (bytes_due == '0) hdr_state = PH_HDR0;
      end
      default: begin
        frame_fin = b[7];
        frame_op = b[3:0];
        hdr_state = PH_HDR1;
      end
    endcase
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t typed_res = '0);
    int gap;
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(b);
    if (typed) decoded_q.push_back(typed_res);
    else if (res_ready) decoded_q.push_back(res_next);
    bytes_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_frame();
    logic [3:0]  op;
    logic        masked;
    logic [31:0] key;
    logic [63:0] len;
    int          form;
    int          i;
    case ($urandom_range(0, 6))
      0: op = OpContinue;
      1: op = OpText;
      2: op = OpBinary;
      3: op = OpClose;
      4: op = OpPing;
      5: op = OpPong;
      default: op = 4'($urandom);
    endcase
    masked = 1'($urandom);
    key = $urandom;
    form = $urandom_range(0, 7);
    if (form < 5)
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 6);
    else
      len = $urandom_range(0, 300);
    send_byte({1'($urandom), 3'($urandom), op});
    if (form < 5) begin
      send_byte({masked, len[6:0]});
    end else if (form < 7) begin
      send_byte({masked, LenCode16});
      for (i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    end else begin
      send_byte({masked, LenCode64});
      for (i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (masked) for (i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (int'(len)) send_byte(8'($urandom));
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result beat, payload_byte %0h", payload_byte);
        failed = 1'b1;
      end else begin
        want = decoded_q.pop_front();
        if (payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte);
          failed = 1'b1;
        end
        if (has_byte !== want.has_byte) begin
          $error("has_byte: expected %0h, got %0h", want.has_byte, has_byte);
          failed = 1'b1;
        end
        if (frame_kind !== want.frame_kind) begin
          $error("frame_kind: expected %0h, got %0h", want.frame_kind, frame_kind);
          failed = 1'b1;
        end
        if (frame_opcode !== want.frame_opcode) begin
          $error("frame_opcode: expected %0h, got %0h", want.frame_opcode, frame_opcode);
          failed = 1'b1;
        end
        if (final_flag !== want.final_flag) begin
          $error("final_flag: expected %0h, got %0h", want.final_flag, final_flag);
          failed = 1'b1;
        end
        if (last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0h, got %0h", want.last_of_frame, last_of_frame);
          failed = 1'b1;
        end
        if (msg_done !== want.msg_done) begin
          $error("msg_done: expected %0h, got %0h", want.msg_done, msg_done);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    dir_rows = '{
      // empty final text frame straight after reset
      '{{1'b1, 3'b000, OpText}, 1'b0, NoResult},
      '{{1'b0, 7'd0}, 1'b1, '{8'h00, 1'b0, KindData, OpText, 1'b1, 1'b1, 1'b1}},
      // masked one-byte ping
      '{{1'b1, 3'b000, OpPing}, 1'b0, NoResult},
      '{{1'b1, 7'd1}, 1'b0, NoResult},
      '{8'hFF, 1'b0, NoResult},
      '{8'h00, 1'b0, NoResult},
      '{8'h00, 1'b0, NoResult},
      '{8'h00, 1'b0, NoResult},
      '{8'h00, 1'b1, '{8'hFF, 1'b1, KindPing, OpPing, 1'b1, 1'b1, 1'b0}},
      // pong with reserved bits set and a 16-bit length
      '{{1'b0, 3'b111, OpPong}, 1'b0, NoResult},
      '{{1'b0, LenCode16}, 1'b0, NoResult},
      '{8'h00, 1'b0, NoResult},
      '{8'h01, 1'b0, NoResult},
      '{8'hFF, 1'b1, '{8'hFF, 1'b1, KindPong, OpPong, 1'b0, 1'b1, 1'b0}},
      // unknown opcode, masked, empty payload
      '{{1'b0, 3'b000, OpUnknown}, 1'b0, NoResult},
      '{{1'b1, LenCode16}, 1'b0, NoResult},
      '{8'h00, 1'b0, NoResult},
      '{8'h00, 1'b0, NoResult},
      '{8'hA5, 1'b0, NoResult},
      '{8'h5A, 1'b0, NoResult},
      '{8'hC3, 1'b0, NoResult},
      '{8'h3C, 1'b1, '{8'h00, 1'b0, KindOther, OpUnknown, 1'b0, 1'b1, 1'b0}},
      // unmasked final continuation: key must be dropped
      '{{1'b1, 3'b000, OpContinue}, 1'b0, NoResult},
      '{{1'b0, 7'd1}, 1'b0, NoResult},
      '{8'h5A, 1'b1, '{8'h5A, 1'b1, KindData, OpContinue, 1'b1, 1'b1, 1'b1}}
    };
    burst_left = $urandom_range(1, 40);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
    while (bytes_sent < StimBytes) send_frame();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (!failed) begin
      $display("websocket_frame_decoder_unit_tb passed");
    end else begin
      $display("websocket_frame_decoder_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("websocket_frame_decoder_unit_tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/wfd_pkg.sv
rtl/wfd_parser.sv
rtl/wfd_out_reg.sv
rtl/websocket_frame_decoder_unit.sv
test/websocket_frame_decoder_unit_tb.sv
